/* rtl/wmimm_pkg.sv */
// Shared types and constants for the sliding-window median / IQR / min / max unit.
// Used by wmimm_ctrl, wmimm_dp and window_median_iqr_min_max_unit; depends on nothing.

package wmimm_pkg;

	// Window length in samples and number of axes carried by an input transaction
	localparam int WINDOW = 64;
	localparam int AXES   = 3;

	// Histogram geometry: one bin per 8-bit value, bin b holds value b - 128
	localparam int NBINS  = 256;
	localparam int BIN_W  = $clog2(NBINS);
	localparam logic [BIN_W-1:0] BIN_OFFSET = BIN_W'(128);
	localparam logic [BIN_W-1:0] BIN_LAST   = BIN_W'(NBINS - 1);

	// Sample width, ring index width, bin count width
	localparam int SAMPLE_W = 8;
	localparam int WP_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W    = $clog2(WINDOW + 1);

	// Quantile thresholds on the cumulative count
	localparam int Q_LOW  = WINDOW / 4;
	localparam int Q_MID  = WINDOW / 2;
	localparam int Q_HIGH = WINDOW * 3 / 4;

	// Configuration register map
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_SELECT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HOP         = CFG_IDX_W'(1);
	localparam logic [7:0] HOP_RESET = 8'd32;

	// Axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic             load;       // capture the selected axis of the input transaction
		logic             hist_rd;    // read the ring slot about to be overwritten
		logic             old_rd;     // read the bin of the departing sample
		logic             old_wr;     // write back the departing bin, decremented
		logic             new_rd;     // read the bin of the arriving sample
		logic             new_wr;     // write back the arriving bin, incremented; store in ring
		logic             clr;        // clear bin at addr
		logic             scan_init;  // reset scan accumulators
		logic             scan_rd;    // read bin at addr for the scan
		logic             out_load;   // move scan results into the output register
		logic [BIN_W-1:0] addr;       // sweep address for clearing and scanning
	} cmd_t;

endpackage

/* rtl/wmimm_ctrl.sv */
// Controller state machine of the window statistics unit.
// Depends on wmimm_pkg; drives wmimm_dp through wmimm_pkg::cmd_t.

module wmimm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  logic [7:0]          hop,
	output wmimm_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HIST_RD,
		ST_OLD_RD,
		ST_OLD_WR,
		ST_NEW_RD,
		ST_NEW_WR,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_OUT
	} state_t;

	state_t                          state_q;
	logic [wmimm_pkg::BIN_W-1:0]     cnt_q;
	logic [wmimm_pkg::CNT_W-1:0]     fill_q;
	logic [7:0]                      hop_cnt_q;
	logic                            emit_q;
	logic                            out_valid_q;

	logic [7:0] hop_eff;
	logic       hop_due;
	logic       full;
	logic       out_free;

	assign hop_eff  = (hop == 8'd0) ? 8'd1 : hop;
	assign hop_due  = ({1'b0, hop_cnt_q} + 9'd1) >= {1'b0, hop_eff};
	assign full     = fill_q >= wmimm_pkg::CNT_W'(wmimm_pkg::WINDOW);
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.addr      = cnt_q;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.hist_rd   = (state_q == ST_HIST_RD);
		cmd.old_rd    = (state_q == ST_OLD_RD);
		cmd.old_wr    = (state_q == ST_OLD_WR);
		cmd.new_rd    = (state_q == ST_NEW_RD);
		cmd.new_wr    = (state_q == ST_NEW_WR);
		cmd.scan_init = (state_q == ST_NEW_WR);
		cmd.clr       = (state_q == ST_CLEAR);
		cmd.scan_rd   = (state_q == ST_SCAN);
		cmd.out_load  = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			fill_q      <= '0;
			hop_cnt_q   <= '0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: load wins over a completed transaction
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == wmimm_pkg::BIN_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (full) begin
							emit_q <= hop_due;
							hop_cnt_q <= hop_due ? 8'd0 : hop_cnt_q + 8'd1;
							state_q <= ST_HIST_RD;
						end else begin
							fill_q <= fill_q + 1'b1;
							emit_q <= (fill_q == wmimm_pkg::CNT_W'(wmimm_pkg::WINDOW - 1));
							if (fill_q == wmimm_pkg::CNT_W'(wmimm_pkg::WINDOW - 1)) begin
								hop_cnt_q <= 8'd0;
							end
							state_q <= ST_NEW_RD;
						end
					end
				end
				ST_HIST_RD:   state_q <= ST_OLD_RD;
				ST_OLD_RD:    state_q <= ST_OLD_WR;
				ST_OLD_WR:    state_q <= ST_NEW_RD;
				ST_NEW_RD:    state_q <= ST_NEW_WR;
				ST_NEW_WR: begin
					cnt_q   <= '0;
					state_q <= emit_q ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == wmimm_pkg::BIN_LAST) begin
						state_q <= ST_SCAN_LAST;
					end
				end
				ST_SCAN_LAST: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/wmimm_dp.sv */
// Datapath of the window statistics unit: sample ring, histogram memory, scan, output register.
// Depends on wmimm_pkg; sequenced by wmimm_ctrl through wmimm_pkg::cmd_t.

module wmimm_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wmimm_pkg::cmd_t                    cmd,
	input  logic [1:0]                         axis_select,
	input  logic signed [wmimm_pkg::SAMPLE_W-1:0] sample_x,
	input  logic signed [wmimm_pkg::SAMPLE_W-1:0] sample_y,
	input  logic signed [wmimm_pkg::SAMPLE_W-1:0] sample_z,
	output logic signed [7:0]                  median,
	output logic        [7:0]                  iqr,
	output logic signed [7:0]                  window_min,
	output logic signed [7:0]                  window_max
);

	// Storage
	logic [wmimm_pkg::SAMPLE_W-1:0] hist_mem [wmimm_pkg::WINDOW];
	logic [wmimm_pkg::CNT_W-1:0]    bin_mem  [wmimm_pkg::NBINS];

	logic [wmimm_pkg::WP_W-1:0]     wp_q;
	logic [wmimm_pkg::SAMPLE_W-1:0] sample_q;
	logic [wmimm_pkg::SAMPLE_W-1:0] hist_rdata_q;
	logic [wmimm_pkg::CNT_W-1:0]    bin_rdata_q;

	// Scan pipeline and accumulators
	logic                           scan_s1;
	logic [wmimm_pkg::BIN_W-1:0]    scan_addr_s1;
	logic [wmimm_pkg::CNT_W-1:0]    cum_q;
	logic                           min_set_q, lo_set_q, mid_set_q, hi_set_q;
	logic [wmimm_pkg::BIN_W-1:0]    min_bin_q, max_bin_q, lo_bin_q, mid_bin_q, hi_bin_q;

	// Output register
	logic [7:0] median_q, iqr_q, min_q, max_q;

	logic [wmimm_pkg::SAMPLE_W-1:0] sel_sample;
	logic [wmimm_pkg::BIN_W-1:0]    old_bin, new_bin, bin_raddr, bin_waddr;
	logic [wmimm_pkg::CNT_W-1:0]    bin_wdata;
	logic                           bin_we, bin_re;
	logic [wmimm_pkg::CNT_W:0]      cum_sum;
	logic                           nonzero;

	// Axis mux: a code with no sample behind it falls back to x
	always_comb begin
		sel_sample = sample_x;
		case (axis_select)
			wmimm_pkg::AXIS_Y: if (wmimm_pkg::AXES > 1) sel_sample = sample_y;
			wmimm_pkg::AXIS_Z: if (wmimm_pkg::AXES > 2) sel_sample = sample_z;
			default:           sel_sample = sample_x;
		endcase
	end

	assign old_bin = hist_rdata_q ^ wmimm_pkg::BIN_OFFSET;
	assign new_bin = sample_q ^ wmimm_pkg::BIN_OFFSET;

	always_comb begin
		bin_re    = cmd.old_rd || cmd.new_rd || cmd.scan_rd;
		bin_raddr = cmd.addr;
		if (cmd.old_rd) begin
			bin_raddr = old_bin;
		end else if (cmd.new_rd) begin
			bin_raddr = new_bin;
		end

		bin_we    = cmd.clr || cmd.old_wr || cmd.new_wr;
		bin_waddr = cmd.addr;
		bin_wdata = '0;
		if (cmd.old_wr) begin
			bin_waddr = old_bin;
			bin_wdata = (bin_rdata_q != '0) ? bin_rdata_q - 1'b1 : '0;
		end else if (cmd.new_wr) begin
			bin_waddr = new_bin;
			bin_wdata = bin_rdata_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (bin_we) begin
			bin_mem[bin_waddr] <= bin_wdata;
		end
		if (bin_re) begin
			bin_rdata_q <= bin_mem[bin_raddr];
		end
		if (cmd.new_wr) begin
			hist_mem[wp_q] <= sample_q;
		end
		if (cmd.hist_rd) begin
			hist_rdata_q <= hist_mem[wp_q];
		end
		if (cmd.load) begin
			sample_q <= sel_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			scan_s1 <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan_rd;
			if (cmd.new_wr) begin
				wp_q <= (wp_q == wmimm_pkg::WP_W'(wmimm_pkg::WINDOW - 1)) ? '0 : wp_q + 1'b1;
			end
		end
	end

	// Scan step: bin_rdata_q holds the count of bin scan_addr_s1
	assign nonzero = (bin_rdata_q != '0);
	assign cum_sum = {1'b0, cum_q} + {1'b0, bin_rdata_q};

	always_ff @(posedge clk) begin
		scan_addr_s1 <= cmd.addr;
		if (cmd.scan_init) begin
			cum_q     <= '0;
			min_set_q <= 1'b0;
			lo_set_q  <= 1'b0;
			mid_set_q <= 1'b0;
			hi_set_q  <= 1'b0;
			min_bin_q <= '0;
			max_bin_q <= '0;
			lo_bin_q  <= '0;
			mid_bin_q <= '0;
			hi_bin_q  <= '0;
		end else if (scan_s1 && nonzero) begin
			cum_q     <= cum_sum[wmimm_pkg::CNT_W-1:0];
			max_bin_q <= scan_addr_s1;
			if (!min_set_q) begin
				min_set_q <= 1'b1;
				min_bin_q <= scan_addr_s1;
			end
			if (!lo_set_q && cum_sum >= (wmimm_pkg::CNT_W+1)'(wmimm_pkg::Q_LOW)) begin
				lo_set_q <= 1'b1;
				lo_bin_q <= scan_addr_s1;
			end
			if (!mid_set_q && cum_sum >= (wmimm_pkg::CNT_W+1)'(wmimm_pkg::Q_MID)) begin
				mid_set_q <= 1'b1;
				mid_bin_q <= scan_addr_s1;
			end
			if (!hi_set_q && cum_sum >= (wmimm_pkg::CNT_W+1)'(wmimm_pkg::Q_HIGH)) begin
				hi_set_q <= 1'b1;
				hi_bin_q <= scan_addr_s1;
			end
		end

		if (cmd.out_load) begin
			median_q <= mid_bin_q ^ wmimm_pkg::BIN_OFFSET;
			iqr_q    <= hi_bin_q - lo_bin_q;
			min_q    <= min_bin_q ^ wmimm_pkg::BIN_OFFSET;
			max_q    <= max_bin_q ^ wmimm_pkg::BIN_OFFSET;
		end
	end

	assign median     = median_q;
	assign iqr        = iqr_q;
	assign window_min = min_q;
	assign window_max = max_q;

endmodule

/* rtl/window_median_iqr_min_max_unit.sv */
// Top level of the sliding-window median / IQR / min / max unit: configuration registers.
// Depends on wmimm_pkg, wmimm_ctrl and wmimm_dp.
//
//   Channel  Handshake                Payload                                Dir
//   input    in_valid / in_stall      sample_x, sample_y, sample_z           in
//   output   out_valid / out_stall    median, iqr, window_min, window_max    out
//   config   cfg_we                   cfg_index, cfg_data                    in
//
// After reset the unit sweeps the 256-bin histogram to zero, one bin per cycle;
// in_stall stays high until the sweep ends. Configuration writes are taken throughout.
// A transaction reads the arriving sample's bin and writes it back incremented; once the
// window is full it first reads and decrements the departing sample's bin. A transaction
// that completes an evaluation adds a scan of every bin through the single read port.
// A finished result waits in the output register; the next input transaction is
// taken meanwhile, and a later result holds in the unit until that register frees.

module window_median_iqr_min_max_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [7:0]                     sample_x,
	input  logic signed [7:0]                     sample_y,
	input  logic signed [7:0]                     sample_z,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [7:0]                     median,
	output logic        [7:0]                     iqr,
	output logic signed [7:0]                     window_min,
	output logic signed [7:0]                     window_max,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [wmimm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wmimm_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [1:0]       axis_select_q;
	logic [7:0]       hop_q;
	wmimm_pkg::cmd_t  cmd;

	// Register file: writes never touch the window or its counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_select_q <= wmimm_pkg::AXIS_X;
			hop_q         <= wmimm_pkg::HOP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wmimm_pkg::REG_AXIS_SELECT: axis_select_q <= cfg_data[1:0];
				wmimm_pkg::REG_HOP:         hop_q         <= cfg_data[7:0];
			endcase
		end
	end

	// Sequence the ring update, the histogram update and the scan
	wmimm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hop       (hop_q),
		.cmd       (cmd)
	);

	// Hold the ring, the histogram and the result register
	wmimm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.axis_select (axis_select_q),
		.sample_x    (sample_x),
		.sample_y    (sample_y),
		.sample_z    (sample_z),
		.median      (median),
		.iqr         (iqr),
		.window_min  (window_min),
		.window_max  (window_max)
	);

endmodule
